// ----- hdl/dcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Dispatch count calibrator package
// Widths, fixed-point constants and register indexes shared by the
// calibrator's modules.
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam int TIME_W     = 32;
	localparam int RATIO_FRAC = 16;
	localparam int SAT_SHIFT  = 3;
	localparam int QUOT_W     = RATIO_FRAC + SAT_SHIFT;
	localparam int CNT_W      = $clog2(QUOT_W);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [QUOT_W-1:0] RATIO_MIN      = QUOT_W'(49152);
	localparam logic [QUOT_W-1:0] RATIO_MAX_WARM = QUOT_W'(81920);
	localparam logic [QUOT_W-1:0] RATIO_MAX_COLD = QUOT_W'(262144);
	localparam logic [QUOT_W-1:0] RATIO_HALF     = QUOT_W'(32768);

	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TIME = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT   = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_COUNT   = CFG_IDX_W'(2);

endpackage

// ----- hdl/dcc_div.sv -----
// ----------------------------------------------------------------------------
// Dispatch count calibrator divider
// Restoring radix-2 divider with one shared subtractor. It produces the
// low quotient bits of the time ratio, one bit per cycle.
// ----------------------------------------------------------------------------
module dcc_div
	import dcc_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [TIME_W-SAT_SHIFT-1:0] num_hi,
	input  logic [QUOT_W-1:0]           num_lo,
	input  logic [TIME_W-1:0]           divisor,
	output logic                        done,
	output logic [QUOT_W-1:0]           quotient
);

	logic [TIME_W-1:0] rem_q;
	logic [QUOT_W-1:0] low_q;
	logic [QUOT_W-1:0] quot_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [TIME_W:0]   shifted;
	logic [TIME_W:0]   trial;
	logic              fits;

	always_comb begin
		shifted = {rem_q, low_q[QUOT_W-1]};
		trial   = shifted - {1'b0, divisor};
		fits    = !trial[TIME_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= {{SAT_SHIFT{1'b0}}, num_hi};
				low_q  <= num_lo;
				cnt_q  <= CNT_W'(QUOT_W - 1);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q  <= fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
				low_q  <= {low_q[QUOT_W-2:0], 1'b0};
				quot_q <= {quot_q[QUOT_W-2:0], fits};
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

// ----- hdl/dcc_seq.sv -----
// ----------------------------------------------------------------------------
// Dispatch count calibrator sequencer
// Steps one request through filtering, ratio division, dead band test,
// scaling and clamping, and holds the result for the output channel.
// ----------------------------------------------------------------------------
module dcc_seq
	import dcc_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [TIME_W-1:0]     target_time,
	input  logic [COUNT_BITS-1:0] eff_min,
	input  logic [COUNT_BITS-1:0] eff_max,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [TIME_W-1:0]     measured_time,
	input  logic                  time_valid,
	input  logic [COUNT_BITS-1:0] dispatch_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COUNT_BITS-1:0] next_count
);

	localparam int PW = COUNT_BITS + QUOT_W;
	localparam int EW = COUNT_BITS + SAT_SHIFT;
	localparam int BW = TIME_W + 5;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_PREP,
		S_DIV,
		S_BAND,
		S_MUL,
		S_FIN,
		S_OUT
	} state_t;

	state_t                state_q;
	logic [TIME_W-1:0]     meas_q;
	logic                  valid_q;
	logic [COUNT_BITS-1:0] disp_q;
	logic [TIME_W-1:0]     filt_q;
	logic [COUNT_BITS-1:0] cur_q;
	logic [COUNT_BITS-1:0] res_q;
	logic [QUOT_W-1:0]     ratio_q;
	logic                  cold_q;
	logic                  up_q;
	logic                  dn_q;
	logic [PW-1:0]         prod_q;
	logic                  out_valid_q;
	logic [COUNT_BITS-1:0] next_count_q;

	logic [TIME_W+1:0]     filt_sum;
	logic [TIME_W-1:0]     filt_next;
	logic                  sat_c;
	logic                  cold_c;
	logic [COUNT_BITS:0]   dbl;
	logic [COUNT_BITS-1:0] dbl_res;
	logic [QUOT_W-1:0]     upper;
	logic [QUOT_W-1:0]     ratio_clamped;
	logic [BW-1:0]         t20;
	logic [BW-1:0]         f21;
	logic [BW-1:0]         f19;
	logic [COUNT_BITS-1:0] scale;
	logic [PW-1:0]         rnd;
	logic [EW-1:0]         prop;
	logic [EW-1:0]         disp_ext;
	logic [EW-1:0]         adj;
	logic [COUNT_BITS-1:0] fin_res;
	logic                  div_start;
	logic                  div_done;
	logic [QUOT_W-1:0]     quot;

	always_comb begin
		filt_sum  = {1'b0, filt_q, 1'b0} + {2'b0, filt_q} + {2'b0, meas_q};
		filt_next = (filt_q == '0) ? meas_q : filt_sum[TIME_W+1:2];

		sat_c  = {{SAT_SHIFT{1'b0}}, target_time} >= {filt_q, {SAT_SHIFT{1'b0}}};
		cold_c = ({1'b0, filt_q, 3'b0} + {3'b0, filt_q, 1'b0}) <
			{4'b0, target_time};

		dbl = {cur_q, 1'b0};
		if (dbl < {1'b0, eff_min}) begin
			dbl_res = eff_min;
		end else if (dbl > {1'b0, eff_max}) begin
			dbl_res = eff_max;
		end else begin
			dbl_res = dbl[COUNT_BITS-1:0];
		end

		upper = cold_q ? RATIO_MAX_COLD : RATIO_MAX_WARM;
		if (quot < RATIO_MIN) begin
			ratio_clamped = RATIO_MIN;
		end else if (quot > upper) begin
			ratio_clamped = upper;
		end else begin
			ratio_clamped = quot;
		end

		t20 = {1'b0, target_time, 4'b0} + {3'b0, target_time, 2'b0};
		f21 = {1'b0, filt_q, 4'b0} + {3'b0, filt_q, 2'b0} + {5'b0, filt_q};
		f19 = {1'b0, filt_q, 4'b0} + {4'b0, filt_q, 1'b0} + {5'b0, filt_q};

		scale = (disp_q == '0) ? COUNT_BITS'(1) : disp_q;

		rnd      = prod_q + PW'(RATIO_HALF);
		prop     = rnd[PW-1:RATIO_FRAC];
		disp_ext = {{SAT_SHIFT{1'b0}}, disp_q};
		if (up_q && prop <= disp_ext && disp_q < eff_max) begin
			adj = disp_ext + EW'(1);
		end else if (dn_q && prop >= disp_ext && disp_q > eff_min) begin
			adj = disp_ext - EW'(1);
		end else begin
			adj = prop;
		end
		if (adj < {{SAT_SHIFT{1'b0}}, eff_min}) begin
			fin_res = eff_min;
		end else if (adj > {{SAT_SHIFT{1'b0}}, eff_max}) begin
			fin_res = eff_max;
		end else begin
			fin_res = adj[COUNT_BITS-1:0];
		end
	end

	assign div_start = (state_q == S_PREP) && !sat_c;

	dcc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num_hi   (target_time[TIME_W-1:SAT_SHIFT]),
		.num_lo   ({target_time[SAT_SHIFT-1:0], {RATIO_FRAC{1'b0}}}),
		.divisor  (filt_q),
		.done     (div_done),
		.quotient (quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cur_q       <= COUNT_BITS'(1);
			filt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						meas_q  <= measured_time;
						valid_q <= time_valid;
						disp_q  <= dispatch_count;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (target_time == '0) begin
						res_q   <= eff_min;
						state_q <= S_OUT;
					end else if (!valid_q || meas_q == '0) begin
						res_q   <= dbl_res;
						state_q <= S_OUT;
					end else begin
						filt_q  <= filt_next;
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					cold_q <= cold_c;
					if (sat_c) begin
						ratio_q <= cold_c ? RATIO_MAX_COLD : RATIO_MAX_WARM;
						state_q <= S_BAND;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						ratio_q <= ratio_clamped;
						state_q <= S_BAND;
					end
				end
				S_BAND: begin
					up_q    <= t20 > f21;
					dn_q    <= t20 < f19;
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= PW'(scale) * PW'(ratio_q);
					state_q <= S_FIN;
				end
				S_FIN: begin
					res_q   <= fin_res;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q  <= 1'b1;
						next_count_q <= res_q;
						cur_q        <= res_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != S_IDLE);
	assign out_valid  = out_valid_q;
	assign next_count = next_count_q;

endmodule

// ----- hdl/dispatch_count_calibrator.sv -----
// ----------------------------------------------------------------------------
// Dispatch count calibrator
// Turns a measured compute time and the dispatch count behind it into the
// dispatch count for the next frame, aiming at a configured target time.
//
// Usage: configuration registers (target time, minimum and maximum count)
// are written through cfg_wr_en, cfg_index and cfg_data while the block is
// idle. A request is taken when in_valid is high and in_stall is low; the
// block raises in_stall while it works on it. One result per request leaves
// on out_valid / next_count and is taken when out_stall is low.
// A request with a zero target or an invalid or zero time goes from the check
// straight to the output register; when the ratio saturates the divider is
// skipped, and otherwise the bit-serial divider produces the 19 quotient bits.
// A new request is taken the cycle after a result is loaded. While the
// receiver stalls, a further result waits in the sequencer until the output
// register is free. Reset clears the registers to a zero target, minimum one
// and maximum all ones, and the kept count to one.
// ----------------------------------------------------------------------------
module dispatch_count_calibrator
	import dcc_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [TIME_W-1:0]     measured_time,
	input  logic                  time_valid,
	input  logic [COUNT_BITS-1:0] dispatch_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COUNT_BITS-1:0] next_count
);

	logic [TIME_W-1:0]     target_q;
	logic [COUNT_BITS-1:0] min_q;
	logic [COUNT_BITS-1:0] max_q;
	logic [COUNT_BITS-1:0] eff_min;
	logic [COUNT_BITS-1:0] eff_max;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			min_q    <= COUNT_BITS'(1);
			max_q    <= '1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TARGET_TIME: target_q <= cfg_data[TIME_W-1:0];
				REG_MIN_COUNT:   min_q    <= cfg_data[COUNT_BITS-1:0];
				REG_MAX_COUNT:   max_q    <= cfg_data[COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		eff_min = (min_q == '0) ? COUNT_BITS'(1) : min_q;
		eff_max = (max_q < eff_min) ? eff_min : max_q;
	end

	dcc_seq #(
		.COUNT_BITS (COUNT_BITS)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.target_time    (target_q),
		.eff_min        (eff_min),
		.eff_max        (eff_max),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.measured_time  (measured_time),
		.time_valid     (time_valid),
		.dispatch_count (dispatch_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.next_count     (next_count)
	);

endmodule
